// ===== rtl/bzcd_pkg.sv =====
// Shared types and constants for the back-EMF zero-crossing detector.
// No dependencies; every other file of the block imports this package.
package bzcd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LOG_DEPTH_DEF   = 1024;

  localparam int DEADBAND_W = 12;
  localparam int CONFIRM_W  = 4;
  localparam int DECIM_W    = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = DECIM_W;
  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 32;
  localparam int EVENT_W    = 6;
  localparam int NUM_PHASES = 3;

  localparam logic [DEADBAND_W-1:0] RST_DEADBAND = 12'd8;
  localparam logic [CONFIRM_W-1:0]  RST_CONFIRM  = 4'd3;
  localparam logic [DECIM_W-1:0]    RST_DECIM    = 16'd128;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEADBAND   = 2'd0,
    CFG_CONFIRM    = 2'd1,
    CFG_DECIMATION = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIGN_UNKNOWN = 2'd0,
    SIGN_LOW     = 2'd1,
    SIGN_HIGH    = 2'd2
  } sign_e;

  typedef struct packed {
    logic [DEADBAND_W-1:0] deadband;
    logic [CONFIRM_W-1:0]  confirm_count;
    logic [DECIM_W-1:0]    decimation;
  } cfg_t;

  // Crossing events of one phase for the scan being processed.
  typedef struct packed {
    logic fall;
    logic rise;
  } phase_ev_t;

endpackage

// ===== rtl/bzcd_neutral.sv =====
// Virtual neutral (sum of three samples divided by three) and per-phase differences.
// Depends on bzcd_pkg.
module bzcd_neutral #(
  parameter int SB = bzcd_pkg::SAMPLE_BITS_DEF,
  parameter int DW = SB + 2
) (
  input  logic [bzcd_pkg::NUM_PHASES-1:0][SB-1:0]        sample_i,
  output logic [SB-1:0]                                  neutral_o,
  output logic signed [bzcd_pkg::NUM_PHASES-1:0][DW-1:0] diff_o
);
  import bzcd_pkg::*;

  localparam int SUM_W  = SB + 2;
  localparam int PW     = 2 * SUM_W;
  localparam int K      = SUM_W + 1;
  // Reciprocal of three, rounded up; exact for every sum below 2**SUM_W.
  localparam longint DIV3_M = ((64'd1 << K) + 64'd2) / 64'd3;

  logic [SUM_W-1:0] sum;
  logic [PW-1:0]    prod;

  assign sum       = SUM_W'(sample_i[0]) + SUM_W'(sample_i[1]) + SUM_W'(sample_i[2]);
  assign prod      = PW'(sum) * PW'(DIV3_M);
  assign neutral_o = prod[K +: SB];

  always_comb begin
    for (int i = 0; i < NUM_PHASES; i++) begin
      diff_o[i] = $signed(DW'(sample_i[i])) - $signed(DW'(neutral_o));
    end
  end

endmodule

// ===== rtl/bzcd_phase.sv =====
// Schmitt qualifier of one phase: confirmed sign, confirmation run and crossing count.
// Depends on bzcd_pkg.
module bzcd_phase #(
  parameter int DW = bzcd_pkg::SAMPLE_BITS_DEF + 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [DW-1:0]                diff_i,
  input  logic [bzcd_pkg::DEADBAND_W-1:0]     deadband_i,
  input  logic [bzcd_pkg::CONFIRM_W-1:0]      confirm_i,
  output bzcd_pkg::phase_ev_t                 ev_o,
  output bzcd_pkg::sign_e                     sign_o,
  output logic [bzcd_pkg::COUNT_W-1:0]        count_o
);
  import bzcd_pkg::*;

  sign_e                 sign_q, sign_d;
  logic [CONFIRM_W-1:0]  run_q, run_d, run_inc, need;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic signed [DW-1:0]  th, th_neg;
  logic                  looking_up, qual, confirmed;
  sign_e                 target;

  assign th     = $signed({{(DW-DEADBAND_W){1'b0}}, deadband_i});
  assign th_neg = -th;
  assign need   = (confirm_i == '0) ? CONFIRM_W'(1) : confirm_i;

  assign looking_up = (sign_q != SIGN_HIGH);
  assign qual       = looking_up ? (diff_i >= th) : (diff_i <= th_neg);
  assign target     = looking_up ? SIGN_HIGH : SIGN_LOW;

  always_comb begin
    if (!qual) begin
      run_inc = '0;
    end else if (run_q < need) begin
      run_inc = run_q + 1'b1;
    end else begin
      run_inc = run_q;
    end
    confirmed = (run_inc >= need);
    run_d     = confirmed ? '0 : run_inc;
    sign_d    = confirmed ? target : sign_q;
    ev_o.rise = confirmed && (sign_q != target) && looking_up;
    ev_o.fall = confirmed && (sign_q != target) && !looking_up;
    count_d   = (ev_o.rise || ev_o.fall) ? count_q + 1'b1 : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q  <= SIGN_UNKNOWN;
      run_q   <= '0;
      count_q <= '0;
    end else if (en_i) begin
      sign_q  <= sign_d;
      run_q   <= run_d;
      count_q <= count_d;
    end
  end

  assign sign_o  = sign_q;
  assign count_o = count_q;

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (ev_o.rise || ev_o.fall) |=> count_q == $past(count_q) + 32'd1)
    else $error("crossing count did not step on a confirmed crossing");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> run_q < $past(need))
    else $error("confirmation run reached the confirm count without a crossing");

endmodule

// ===== rtl/bzcd_logger.sv =====
// Decimation counter, pending-event accumulator and log ring slot.
// Depends on bzcd_pkg.
module bzcd_logger #(
  parameter int LOG_DEPTH = bzcd_pkg::LOG_DEPTH_DEF,
  parameter int SW        = $clog2(LOG_DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [bzcd_pkg::DECIM_W-1:0]    decimation_i,
  input  logic [bzcd_pkg::EVENT_W-1:0]    ev_i,
  output logic                            strobe_o,
  output logic [bzcd_pkg::EVENT_W-1:0]    log_events_o,
  output logic [SW-1:0]                   log_slot_o
);
  import bzcd_pkg::*;

  logic [DECIM_W-1:0] dcnt_q, dcnt_d, dcnt_inc;
  logic [EVENT_W-1:0] pend_q, pend_d, pend_or;
  logic [SW-1:0]      slot_q, slot_d;

  always_comb begin
    dcnt_inc     = dcnt_q + 1'b1;
    strobe_o     = (dcnt_inc >= decimation_i) || (dcnt_inc == '0);
    pend_or      = pend_q | ev_i;
    dcnt_d       = strobe_o ? '0 : dcnt_inc;
    pend_d       = strobe_o ? '0 : pend_or;
    log_events_o = strobe_o ? pend_or : '0;
    log_slot_o   = strobe_o ? slot_q : '0;
    if (!strobe_o) begin
      slot_d = slot_q;
    end else if (slot_q == SW'(LOG_DEPTH - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      pend_q <= '0;
      slot_q <= '0;
    end else if (en_i) begin
      dcnt_q <= dcnt_d;
      pend_q <= pend_d;
      slot_q <= slot_d;
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SW'(LOG_DEPTH - 1))
    else $error("log slot beyond ring depth");

endmodule

// ===== rtl/bemf_zero_cross_detector_top.sv =====
// Back-EMF zero-crossing detector, top level: input register, configuration, result register.
// Depends on bzcd_pkg, bzcd_neutral, bzcd_phase and bzcd_logger.
//
// Takes one three-phase scan per clock cycle unless the sink stalls, and returns one result
// item per scan, in order. An accepted scan sits in the input register; the neutral, the
// three phase qualifiers and the log bookkeeping then update together as it moves into the
// result register, and a full stream runs at one item per cycle as long as the sink keeps
// tready high. The sign and crossing-count fields come straight from the qualifier state,
// which only advances when a new result is loaded. Configuration writes are always
// accepted and take effect on the next scan processed.
module bemf_zero_cross_detector_top #(
  parameter int SAMPLE_BITS = bzcd_pkg::SAMPLE_BITS_DEF,
  parameter int LOG_DEPTH   = bzcd_pkg::LOG_DEPTH_DEF,
  localparam int SW         = $clog2(LOG_DEPTH),
  localparam int IN_RAW     = 3 * SAMPLE_BITS + bzcd_pkg::TIME_W,
  localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW    = SAMPLE_BITS + 3 * bzcd_pkg::EVENT_W + SW + bzcd_pkg::TIME_W
                              + 3 * bzcd_pkg::COUNT_W,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // sample_a, sample_b, sample_c, timestamp_us, zero pad
  input  logic [IN_W-1:0]                   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // neutral, events_now, sign_state, log_events, log_slot, log_time,
  // crossings_a, crossings_b, crossings_c, zero pad
  output logic [OUT_W-1:0]                  m_axis_tdata_o,
  // log_strobe
  output logic                              m_axis_tuser_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bzcd_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bzcd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bzcd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int DW = ((SB > DEADBAND_W) ? SB : DEADBAND_W) + 2;

  cfg_t cfg_q;

  logic                           in_valid_q;
  logic [NUM_PHASES-1:0][SB-1:0]  sample_q;
  logic [TIME_W-1:0]              ts_q;

  logic                           out_valid_q;
  logic [SB-1:0]                  neutral_q;
  logic [EVENT_W-1:0]             ev_q;
  logic                           strobe_q;
  logic [EVENT_W-1:0]             log_ev_q;
  logic [SW-1:0]                  log_slot_q;
  logic [TIME_W-1:0]              log_time_q;

  logic                           adv, load_in;
  logic [SB-1:0]                  neutral;
  logic signed [NUM_PHASES-1:0][DW-1:0] diff;
  phase_ev_t [NUM_PHASES-1:0]     pev;
  sign_e [NUM_PHASES-1:0]         sign;
  logic [NUM_PHASES-1:0][COUNT_W-1:0] count;
  logic [EVENT_W-1:0]             ev_now, sign_state;
  logic                           strobe;
  logic [EVENT_W-1:0]             log_ev;
  logic [SW-1:0]                  log_slot;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband      <= RST_DEADBAND;
      cfg_q.confirm_count <= RST_CONFIRM;
      cfg_q.decimation    <= RST_DECIM;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_DEADBAND:   cfg_q.deadband      <= cfg_data_i[DEADBAND_W-1:0];
        CFG_CONFIRM:    cfg_q.confirm_count <= cfg_data_i[CONFIRM_W-1:0];
        CFG_DECIMATION: cfg_q.decimation    <= cfg_data_i[DECIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign load_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_in) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      sample_q[0] <= s_axis_tdata_i[0 +: SB];
      sample_q[1] <= s_axis_tdata_i[SB +: SB];
      sample_q[2] <= s_axis_tdata_i[2*SB +: SB];
      ts_q        <= s_axis_tdata_i[3*SB +: TIME_W];
    end
  end

  // ---------------- datapath ----------------
  bzcd_neutral #(.SB(SB), .DW(DW)) u_neutral (
    .sample_i  (sample_q),
    .neutral_o (neutral),
    .diff_o    (diff)
  );

  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
    bzcd_phase #(.DW(DW)) u_phase (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (adv),
      .diff_i     (diff[p]),
      .deadband_i (cfg_q.deadband),
      .confirm_i  (cfg_q.confirm_count),
      .ev_o       (pev[p]),
      .sign_o     (sign[p]),
      .count_o    (count[p])
    );
    assign ev_now[2*p +: 2]     = {pev[p].fall, pev[p].rise};
    assign sign_state[2*p +: 2] = sign[p];
  end

  bzcd_logger #(.LOG_DEPTH(LOG_DEPTH), .SW(SW)) u_logger (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .decimation_i (cfg_q.decimation),
    .ev_i         (ev_now),
    .strobe_o     (strobe),
    .log_events_o (log_ev),
    .log_slot_o   (log_slot)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neutral_q  <= neutral;
      ev_q       <= ev_now;
      strobe_q   <= strobe;
      log_ev_q   <= log_ev;
      log_slot_q <= log_slot;
      log_time_q <= strobe ? ts_q : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = strobe_q;
  assign m_axis_tdata_o  = OUT_W'({count[2], count[1], count[0], log_time_q, log_slot_q,
                                   log_ev_q, sign_state, ev_q, neutral_q});

  // ---------------- checks ----------------
  a_rise_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ev_q[0] |-> sign[0] == SIGN_HIGH)
    else $error("phase A rise reported without a high sign");

  a_one_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(ev_q[0] && ev_q[1]) && !(ev_q[2] && ev_q[3]) && !(ev_q[4] && ev_q[5]))
    else $error("rise and fall on the same phase in one scan");

  a_log_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !strobe_q |-> log_ev_q == '0 && log_time_q == '0 && log_slot_q == '0)
    else $error("log fields set without a log strobe");

  a_ev_in_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && strobe_q |-> (ev_q & ~log_ev_q) == '0)
    else $error("scan events missing from the log entry");

endmodule

// ===== tb/bemf_zero_cross_detector_top_tb.sv =====
// Self-checking testbench for bemf_zero_cross_detector_top.
// Directed rows and random burst scans are checked against fixed results or a predictor of the
// neutral, three Schmitt qualifiers and log decimation. Depends on bzcd_pkg and the block's RTL.
module bemf_zero_cross_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bzcd_pkg::*;

  localparam int SMP_W  = SAMPLE_BITS_DEF;
  localparam int IN_RAW = 3 * SMP_W + TIME_W;
  localparam int IN_W   = ((IN_RAW + 7) / 8) * 8;
  localparam int SLOT_W = $clog2(LOG_DEPTH_DEF);
  localparam int OUT_W  = ((SMP_W + 3 * EVENT_W + SLOT_W + TIME_W + 3 * COUNT_W + 7) / 8) * 8;

  typedef struct packed {
    logic [SMP_W-1:0]   neutral;
    logic [EVENT_W-1:0] events_now;
    logic [EVENT_W-1:0] sign_state;
    logic               log_strobe;
    logic [EVENT_W-1:0] log_events;
    logic [SLOT_W-1:0]  log_slot;
    logic [TIME_W-1:0]  log_time;
    logic [COUNT_W-1:0] crossings_a;
    logic [COUNT_W-1:0] crossings_b;
    logic [COUNT_W-1:0] crossings_c;
  } scan_result_t;

  typedef struct {
    bit                    is_cfg;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [SMP_W-1:0]      a;
    logic [SMP_W-1:0]      b;
    logic [SMP_W-1:0]      c;
    logic [TIME_W-1:0]     ts;
    bit                    typed;
    scan_result_t          exp;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bemf_zero_cross_detector_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: register copies, per-phase qualifier state and log bookkeeping.
  logic [DEADBAND_W-1:0] deadband_q = RST_DEADBAND;
  logic [CONFIRM_W-1:0]  confirm_q  = RST_CONFIRM;
  logic [DECIM_W-1:0]    decim_q    = RST_DECIM;
  sign_e                 sign_q[NUM_PHASES] = '{SIGN_UNKNOWN, SIGN_UNKNOWN, SIGN_UNKNOWN};
  logic [CONFIRM_W-1:0]  run_q[NUM_PHASES]  = '{'0, '0, '0};
  logic [COUNT_W-1:0]    cross_q[NUM_PHASES] = '{0, 0, 0};
  logic [EVENT_W-1:0]    pending_q  = '0;
  logic [DECIM_W-1:0]    decim_cnt_q = '0;
  logic [SLOT_W-1:0]     slot_q     = '0;

  scan_result_t expected_scans[$];
  int           mismatches = 0;
  int           scans_sent = 0;
  bit           snd_quiet = 1'b0;
  bit           rcv_quiet = 1'b0;
  logic         sink_hold = 1'b0;
  int           stall_left = 0;

  // Burst generator state for the random part.
  int           burst_left = 0;
  int           burst_lvl[NUM_PHASES];
  int           noise_amp = 0;
  bit           noisy_burst = 1'b0;
  logic [TIME_W-1:0] ts_now = '0;

  function automatic scan_result_t predict_scan(logic [SMP_W-1:0] sa, logic [SMP_W-1:0] sb,
                                                logic [SMP_W-1:0] sc, logic [TIME_W-1:0] ts);
    logic [SMP_W-1:0] smp[NUM_PHASES];
    logic [SMP_W+1:0] sum;
    int               diff;
    int               thr;
    int               need;
    bit               up;
    bit               qual;
    sign_e            tgt;
    sign_e            prev;
    scan_result_t     r;
    r = '0;
    smp[0] = sa;
    smp[1] = sb;
    smp[2] = sc;
    sum = sa + sb + sc;
    r.neutral = SMP_W'(sum / 3);
    thr  = int'(deadband_q);
    need = (confirm_q == 0) ? 1 : int'(confirm_q);
    for (int p = 0; p < NUM_PHASES; p++) begin
      diff = int'(smp[p]) - int'(r.neutral);
      up   = (sign_q[p] != SIGN_HIGH);
      qual = up ? (diff >= thr) : (diff <= -thr);
      tgt  = up ? SIGN_HIGH : SIGN_LOW;
      if (qual) begin
        if (int'(run_q[p]) < need) run_q[p] = run_q[p] + 1'b1;
      end else begin
        run_q[p] = '0;
      end
      if (int'(run_q[p]) >= need) begin
        prev = sign_q[p];
        run_q[p] = '0;
        sign_q[p] = tgt;
        if (prev != tgt) begin
          cross_q[p] = cross_q[p] + 1'b1;
          r.events_now[2*p + (up ? 0 : 1)] = 1'b1;
        end
      end
      r.sign_state[2*p +: 2] = sign_q[p];
    end
    pending_q = pending_q | r.events_now;
    decim_cnt_q = decim_cnt_q + 1'b1;
    // A zero decimation register logs on every scan; a counter that wraps to zero forces a log.
    if (decim_cnt_q >= decim_q || decim_cnt_q == 0) begin
      decim_cnt_q  = '0;
      r.log_strobe = 1'b1;
      r.log_events = pending_q;
      r.log_slot   = slot_q;
      r.log_time   = ts;
      pending_q    = '0;
      slot_q       = slot_q + 1'b1;
    end
    r.crossings_a = cross_q[0];
    r.crossings_b = cross_q[1];
    r.crossings_c = cross_q[2];
    return r;
  endfunction

  function automatic int draw_idle(bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, 16));
  endfunction

  function automatic stim_row_t scan_row(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                         logic [SMP_W-1:0] c, logic [TIME_W-1:0] ts);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = CFG_DEADBAND;
    r.reg_val = '0;
    r.a       = a;
    r.b       = b;
    r.c       = c;
    r.ts      = ts;
    r.typed   = 1'b0;
    r.exp     = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = scan_row('0, '0, '0, '0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] data;
    data = val;
    // Bits above the register's width must be ignored by the block.
    if ($urandom_range(0, 1) == 1) begin
      case (idx)
        CFG_DEADBAND: data[CFG_DATA_W-1:DEADBAND_W] = (CFG_DATA_W-DEADBAND_W)'($urandom);
        CFG_CONFIRM:  data[CFG_DATA_W-1:CONFIRM_W] = (CFG_DATA_W-CONFIRM_W)'($urandom);
        default: ;
      endcase
    end
    s_tvalid <= 1'b0;
    while (expected_scans.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (cfg_ready !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_DEADBAND:   deadband_q = data[DEADBAND_W-1:0];
      CFG_CONFIRM:    confirm_q  = data[CONFIRM_W-1:0];
      CFG_DECIMATION: decim_q    = data[DECIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_scan(stim_row_t row);
    int           gap;
    scan_result_t pred;
    gap = draw_idle(snd_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-IN_RAW){1'b0}}, row.ts, row.c, row.b, row.a};
    @(posedge clk_i);
    while (s_tready !== 1'b1) @(posedge clk_i);
    pred = predict_scan(row.a, row.b, row.c, row.ts);
    expected_scans.push_back(row.typed ? row.exp : pred);
    scans_sent++;
    @(negedge clk_i);
  endtask

  // Mostly bursts that hold each phase above or below the others for up to 24 scans,
  // with some noise bursts and occasional broken samples in between.
  task automatic make_scan(output stim_row_t row);
    int v[NUM_PHASES];
    if (burst_left == 0) begin
      burst_left  = int'($urandom_range(1, 24));
      noisy_burst = ($urandom_range(0, 4) == 0);
      noise_amp   = int'($urandom_range(0, 64));
      for (int p = 0; p < NUM_PHASES; p++)
        burst_lvl[p] = 2048 + ($urandom_range(0, 1) == 1 ? 1 : -1) * int'($urandom_range(0, 2047));
    end
    burst_left--;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (noisy_burst) begin
        if ($urandom_range(0, 7) == 0) v[p] = int'($urandom_range(0, 1)) * 4095;
        else v[p] = int'($urandom_range(0, 4095));
      end else begin
        v[p] = burst_lvl[p] + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
      end
      if (v[p] < 0) v[p] = 0;
      if (v[p] > 4095) v[p] = 4095;
    end
    if (!noisy_burst && $urandom_range(0, 15) == 0)
      v[$urandom_range(0, 2)] = int'($urandom_range(0, 4095));
    if ($urandom_range(0, 31) == 0) ts_now = $urandom;
    else ts_now = ts_now + $urandom_range(1, 200);
    row = scan_row(SMP_W'(v[0]), SMP_W'(v[1]), SMP_W'(v[2]), ts_now);
  endtask

  // Result side: stall per item, compare against the oldest expectation.
  always @(posedge clk_i) begin : sink_check
    scan_result_t want;
    scan_result_t got;
    if (rst_ni && m_tvalid === 1'b1 && m_tready) begin
      got = {m_tdata[11:0], m_tdata[17:12], m_tdata[23:18], m_tuser, m_tdata[29:24],
             m_tdata[39:30], m_tdata[71:40], m_tdata[103:72], m_tdata[135:104],
             m_tdata[167:136]};
      if (expected_scans.size() == 0) begin
        $error("result item with no scan outstanding");
        mismatches++;
      end else begin
        want = expected_scans.pop_front();
        check_field("neutral", 32'(want.neutral), 32'(got.neutral));
        check_field("events_now", 32'(want.events_now), 32'(got.events_now));
        check_field("sign_state", 32'(want.sign_state), 32'(got.sign_state));
        check_field("log_strobe", 32'(want.log_strobe), 32'(got.log_strobe));
        check_field("log_events", 32'(want.log_events), 32'(got.log_events));
        check_field("log_slot", 32'(want.log_slot), 32'(got.log_slot));
        check_field("log_time", want.log_time, got.log_time);
        check_field("crossings_a", want.crossings_a, got.crossings_a);
        check_field("crossings_b", want.crossings_b, got.crossings_b);
        check_field("crossings_c", want.crossings_c, got.crossings_c);
      end
      stall_left = draw_idle(rcv_quiet);
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  always @(negedge clk_i) m_tready <= (stall_left == 0) && !sink_hold;

  // One long hold-off on the result side while scans keep coming, to fill the block.
  initial begin
    wait (scans_sent >= 300);
    @(negedge clk_i);
    sink_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    stim_row_t plan[$];
    stim_row_t row;
    int        dec;
    int        db;
    int        cf;
    int        len;

    // Reset configuration: deadband 8, three confirmations, log every 128 scans.
    row = scan_row(12'd0, 12'd0, 12'd0, 32'd0);
    row.typed = 1'b1;
    row.exp = '0;
    plan.push_back(row);
    row = scan_row(12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    row.typed = 1'b1;
    row.exp = '{neutral: 12'd4095, default: '0};
    plan.push_back(row);
    // Phase A well above the neutral: leaving the unknown sign counts as a rise.
    plan.push_back(scan_row(12'd4095, 12'd0, 12'd0, 32'd10));
    plan.push_back(scan_row(12'd4095, 12'd0, 12'd0, 32'd11));
    row = scan_row(12'd4095, 12'd0, 12'd0, 32'd12);
    row.typed = 1'b1;
    row.exp = '{neutral: 12'd1365, events_now: 6'h01, sign_state: 6'h02, crossings_a: 32'd1,
                default: '0};
    plan.push_back(row);
    plan.push_back(scan_row(12'd0, 12'd4095, 12'd4095, 32'd20));
    plan.push_back(scan_row(12'd0, 12'd4095, 12'd4095, 32'd21));
    plan.push_back(scan_row(12'd0, 12'd4095, 12'd4095, 32'd22));
    // Zero deadband, zero confirm count and zero decimation.
    plan.push_back(cfg_row(CFG_DEADBAND, 16'd0));
    plan.push_back(cfg_row(CFG_CONFIRM, 16'd0));
    plan.push_back(cfg_row(CFG_DECIMATION, 16'd0));
    plan.push_back(scan_row(12'd100, 12'd100, 12'd100, 32'd30));
    plan.push_back(scan_row(12'd100, 12'd100, 12'd100, 32'd31));
    plan.push_back(scan_row(12'd1, 12'd2, 12'd3, 32'd32));
    plan.push_back(scan_row(12'd4095, 12'd4095, 12'd0, 32'd33));
    // Largest settings: nothing can qualify.
    plan.push_back(cfg_row(CFG_DEADBAND, 16'd4095));
    plan.push_back(cfg_row(CFG_CONFIRM, 16'd15));
    plan.push_back(cfg_row(CFG_DECIMATION, 16'd65535));
    plan.push_back(scan_row(12'd4095, 12'd0, 12'd0, 32'd40));
    plan.push_back(scan_row(12'd0, 12'd0, 12'd4095, 32'd41));
    plan.push_back(cfg_row(CFG_DEADBAND, 16'd1));
    plan.push_back(cfg_row(CFG_CONFIRM, 16'd1));
    plan.push_back(cfg_row(CFG_DECIMATION, 16'd1));
    plan.push_back(scan_row(12'd2048, 12'd2047, 12'd2049, 32'd50));
    plan.push_back(scan_row(12'd2049, 12'd2048, 12'd2047, 32'd51));
    plan.push_back(scan_row(12'hAAA, 12'h555, 12'hFFF, 32'hAAAA_5555));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    snd_quiet = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_scan(plan[i]);
      if (i == 8) snd_quiet = 1'b0;
    end

    // Random phases; most log on every scan so the log slot wraps.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin dec = 1;     db = 8;    cf = 1;  end
        1: begin dec = 0;     db = 0;    cf = 0;  end
        2: begin dec = 1;     db = 30;   cf = 3;  end
        3: begin dec = 2;     db = 1;    cf = 2;  end
        4: begin dec = 65535; db = 4095; cf = 15; end
        5: begin dec = 1;     db = int'($urandom_range(0, 400)); cf = int'($urandom_range(1, 15)); end
        6: begin dec = 0;     db = 2;    cf = 1;  end
        7: begin dec = int'($urandom_range(3, 40)); db = int'($urandom_range(0, 100)); cf = 15; end
        default: begin dec = 1; db = 5; cf = 4; end
      endcase
      write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
      write_reg(CFG_CONFIRM, CFG_DATA_W'(cf));
      write_reg(CFG_DECIMATION, CFG_DATA_W'(dec));
      snd_quiet = ($urandom_range(0, 3) == 0);
      rcv_quiet = ($urandom_range(0, 3) == 0);
      if (dec <= 1) len = 200;
      else if (dec == 2) len = 40;
      else if (dec == 65535) len = 20;
      else len = 30;
      repeat (len) begin
        make_scan(row);
        send_scan(row);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
